// ----- hdl/sfr_pkg.sv -----
`timescale 1ns / 1ps

package sfr_pkg;

  localparam logic [7:0] SyncFirst     = 8'hAA;
  localparam logic [7:0] SyncSecond    = 8'hBB;
  localparam logic [8:0] MinFrameBytes = 9'd8;
  localparam logic [8:0] StatusIndex   = 9'd6;
  localparam logic [8:0] XorFirstIndex = 9'd2;

  typedef struct packed {
    logic       payload_valid;
    logic [8:0] payload_index;
    logic [7:0] payload_byte;
    logic       frame_done;
    logic       frame_ok;
  } sfr_result_t;

endpackage

// ----- hdl/sfr_in_if.sv -----
`timescale 1ns / 1ps

interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- hdl/sfr_out_if.sv -----
`timescale 1ns / 1ps

interface sfr_out_if;
  logic       valid;
  logic       ready;
  logic       payload_valid;
  logic [8:0] payload_index;
  logic [7:0] payload_byte;
  logic       frame_done;
  logic       frame_ok;

  modport source (
    output valid, output payload_valid, output payload_index, output payload_byte,
    output frame_done, output frame_ok, input ready
  );
  modport sink (
    input valid, input payload_valid, input payload_index, input payload_byte,
    input frame_done, input frame_ok, output ready
  );
endinterface

// ----- hdl/sfr_core.sv -----
`timescale 1ns / 1ps

module sfr_core
  import sfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  rx_byte,
  output sfr_result_t result
);

  logic       escape_r, escape_nxt;
  logic       in_frame_r, in_frame_nxt;
  logic [8:0] count_r, count_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] status_r, status_nxt;
  logic [7:0] xor_r, xor_nxt;

  logic       store;
  logic       start;
  logic       last;
  logic [7:0] len_eff;
  logic [7:0] status_eff;

  always_comb begin
    escape_nxt   = escape_r;
    in_frame_nxt = in_frame_r;
    count_nxt    = count_r;
    len_nxt      = len_r;
    status_nxt   = status_r;
    xor_nxt      = xor_r;
    store        = 1'b0;
    start        = 1'b0;

    // sync pattern and escape handling
    if (rx_byte == SyncFirst) begin
      escape_nxt = 1'b1;
      store      = in_frame_r;
    end else if (escape_r) begin
      escape_nxt = 1'b0;
      start      = (rx_byte == SyncSecond);
    end else begin
      store = in_frame_r;
    end

    len_eff    = (count_r == 9'd0) ? rx_byte : len_r;
    status_eff = (count_r == StatusIndex) ? rx_byte : status_r;
    last       = (count_r == {1'b0, len_eff} + 9'd1);

    if (start) begin
      in_frame_nxt = 1'b1;
      count_nxt    = 9'd0;
      len_nxt      = 8'd0;
      status_nxt   = 8'd0;
      xor_nxt      = 8'd0;
    end else if (store) begin
      len_nxt    = len_eff;
      status_nxt = status_eff;
      if (last) begin
        in_frame_nxt = 1'b0;
        count_nxt    = 9'd0;
      end else begin
        if (count_r >= XorFirstIndex && count_r <= {1'b0, len_eff}) begin
          xor_nxt = xor_r ^ rx_byte;
        end
        count_nxt = count_r + 9'd1;
      end
    end

    result.payload_valid = store;
    result.payload_index = store ? count_r : 9'd0;
    result.payload_byte  = store ? rx_byte : 8'd0;
    result.frame_done    = store && last;
    result.frame_ok      = store && last && (count_r + 9'd1 >= MinFrameBytes) &&
                           (status_eff == 8'd0) && (xor_r == rx_byte);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_r   <= 1'b0;
      in_frame_r <= 1'b0;
      count_r    <= 9'd0;
      len_r      <= 8'd0;
      status_r   <= 8'd0;
      xor_r      <= 8'd0;
    end else if (step) begin
      escape_r   <= escape_nxt;
      in_frame_r <= in_frame_nxt;
      count_r    <= count_nxt;
      len_r      <= len_nxt;
      status_r   <= status_nxt;
      xor_r      <= xor_nxt;
    end
  end

endmodule

// ----- hdl/sync_frame_receiver_xor_check.sv -----
`timescale 1ns / 1ps
// a result becomes valid, at the earliest, once its byte has passed the input register and then the result register
// throughput: one byte per cycle while out_ch.ready does not hold the output, as the frame state updates once per byte
// input register feeds the frame logic, result register feeds the output
// reset (synchronous, rst_n low) empties both stages and clears frame state

module sync_frame_receiver_xor_check
  import sfr_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  sfr_in_if.sink          in_ch,
  sfr_out_if.source       out_ch
);

  logic        in_vld_r, in_vld_nxt;
  logic [7:0]  in_byte_r;
  logic        out_vld_r, out_vld_nxt;
  sfr_result_t out_res_r;
  sfr_result_t res;
  logic        out_adv;
  logic        s1_adv;

  assign out_adv     = !out_vld_r || out_ch.ready;
  assign s1_adv      = in_vld_r && out_adv;
  assign in_ch.ready = !in_vld_r || out_adv;

  assign in_vld_nxt  = in_ch.ready ? in_ch.valid : in_vld_r;
  assign out_vld_nxt = out_adv ? in_vld_r : out_vld_r;

  sfr_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (s1_adv),
    .rx_byte (in_byte_r),
    .result  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.rx_byte;
    end
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.payload_valid = out_res_r.payload_valid;
  assign out_ch.payload_index = out_res_r.payload_index;
  assign out_ch.payload_byte  = out_res_r.payload_byte;
  assign out_ch.frame_done    = out_res_r.frame_done;
  assign out_ch.frame_ok      = out_res_r.frame_ok;

endmodule
